### rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the periodic task dispatcher
// Request and result payloads, request codes and field widths.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam int TICK_W         = 32;
	localparam int PERIOD_W       = 16;
	localparam int OFFSET_W       = 8;
	localparam int SLOT_FIELD_W   = 4;
	localparam int CFG_W          = 8;

	localparam logic [2:0] REQ_TIMER   = 3'd0;
	localparam logic [2:0] REQ_INSTALL = 3'd1;
	localparam logic [2:0] REQ_DELETE  = 3'd2;
	localparam logic [2:0] REQ_PAUSE   = 3'd3;
	localparam logic [2:0] REQ_RESUME  = 3'd4;

	typedef struct packed {
		logic [2:0]              req_type;
		logic [SLOT_FIELD_W-1:0] task_slot;
		logic [PERIOD_W-1:0]     period;
		logic [OFFSET_W-1:0]     phase_offset;
	} ptd_req_t;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] due_task;
		logic                    last_in_run;
		logic [TICK_W-1:0]       tick_value;
	} ptd_res_t;

endpackage

### rtl/core/ptd_rem_unit.sv
// ----------------------------------------------------------------------------
// ptd_rem_unit: bit-serial remainder of the tick count by a slot period
// Restoring division, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ptd_rem_unit import ptd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [TICK_W-1:0]   dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic                done,
	output logic [PERIOD_W-1:0] rem
);

	localparam int CNT_W = $clog2(TICK_W + 1);

	logic [TICK_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] div_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic [PERIOD_W-1:0] next_rem;

	// remainder stays below the divisor, so the trial fits one extra bit
	always_comb begin
		trial    = {rem_q, dvd_q[TICK_W-1]};
		diff     = trial - {1'b0, div_q};
		next_rem = (trial >= {1'b0, div_q}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(TICK_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			rem_q <= next_rem;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/core/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher: time-triggered task slot scheduler
// Divides timer events into ticks and reports due slots on every tick.
// ----------------------------------------------------------------------------
// Table requests and non-ticking timer events are taken while idle; busy stays low.
// A ticking event walks all slots, highest first: an idle slot passes through WALK,
// a live slot through WALK, DIV (serial remainder) and CHECK, and FLUSH closes the run.
// Results leave one per strobe cycle and cannot be stalled. Reset clears the table
// marks, counters and divisor to 1.
module periodic_task_dispatcher import ptd_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ptd_req_t         req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             result_strobe,
	output ptd_res_t         result
);

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WALK  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    div_cfg_q;
	logic [CFG_W-1:0]    event_cnt_q;
	logic [TICK_W-1:0]   tick_q;
	logic [TASK_SLOTS-1:0] present_q;
	logic [TASK_SLOTS-1:0] paused_q;
	logic [PERIOD_W-1:0] period_q [TASK_SLOTS];
	logic [OFFSET_W-1:0] offset_q [TASK_SLOTS];
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   pend_q;
	logic                pend_v_q;
	logic                strobe_q;
	ptd_res_t            result_q;

	logic                accept;
	logic                in_range;
	logic [SLOT_W-1:0]   wr_idx;
	logic [CFG_W:0]      next_cnt;
	logic [CFG_W:0]      divisor;
	logic                tick_now;
	logic                sel_live;
	logic                rem_start;
	logic                rem_done;
	logic [PERIOD_W-1:0] rem;
	logic                match;
	logic                emit;
	logic                emit_last;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign in_range = ({1'b0, req.task_slot} < (SLOT_FIELD_W + 1)'(TASK_SLOTS));
	assign wr_idx   = req.task_slot[SLOT_W-1:0];
	assign next_cnt = {1'b0, event_cnt_q} + (CFG_W + 1)'(1);
	// a zero divisor acts as one
	assign divisor  = (div_cfg_q == '0) ? (CFG_W + 1)'(1) : {1'b0, div_cfg_q};
	assign tick_now = accept && (req.req_type == REQ_TIMER) && (next_cnt >= divisor);

	assign sel_live  = present_q[idx_q] && !paused_q[idx_q] && (period_q[idx_q] != '0);
	assign rem_start = (state_q == ST_WALK) && sel_live;
	assign match     = (rem == {{(PERIOD_W - OFFSET_W){1'b0}}, offset_q[idx_q]});
	assign emit      = pend_v_q && (((state_q == ST_CHECK) && match) || (state_q == ST_FLUSH));
	assign emit_last = (state_q == ST_FLUSH);

	ptd_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (tick_q),
		.divisor  (period_q[idx_q]),
		.done     (rem_done),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cfg_q <= CFG_W'(1);
		end else if (cfg_we) begin
			div_cfg_q <= cfg_wdata;
		end
	end

	// timer divider, tick counter and slot marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_cnt_q <= '0;
			tick_q      <= '0;
			present_q   <= '0;
			paused_q    <= '0;
		end else if (accept) begin
			if (req.req_type == REQ_TIMER) begin
				if (tick_now) begin
					event_cnt_q <= '0;
					tick_q      <= tick_q + TICK_W'(1);
				end else begin
					event_cnt_q <= next_cnt[CFG_W-1:0];
				end
			end else if (in_range) begin
				unique case (req.req_type)
					REQ_INSTALL: begin
						present_q[wr_idx] <= 1'b1;
						paused_q[wr_idx]  <= 1'b0;
					end
					REQ_DELETE: begin
						present_q[wr_idx] <= 1'b0;
						paused_q[wr_idx]  <= 1'b0;
					end
					REQ_PAUSE:  paused_q[wr_idx] <= 1'b1;
					REQ_RESUME: paused_q[wr_idx] <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_range && (req.req_type == REQ_INSTALL)) begin
			period_q[wr_idx] <= req.period;
			offset_q[wr_idx] <= req.phase_offset;
		end
	end

	// slot walk: hold the last due slot until the next one or the end of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					if (tick_now) begin
						state_q  <= ST_WALK;
						idx_q    <= LAST_SLOT;
						pend_v_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (sel_live) begin
						state_q <= ST_DIV;
					end else if (idx_q == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q - SLOT_W'(1);
					end
				end
				ST_DIV: begin
					if (rem_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (match) begin
						pend_q   <= idx_q;
						pend_v_q <= 1'b1;
					end
					if (idx_q == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_WALK;
						idx_q   <= idx_q - SLOT_W'(1);
					end
				end
				ST_FLUSH: begin
					state_q  <= ST_IDLE;
					pend_v_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.due_task    <= SLOT_FIELD_W'(pend_q);
			result_q.last_in_run <= emit_last;
			result_q.tick_value  <= tick_q;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

### tb/ptd_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_schedule_checker: due-task predictor and result checker
// Tracks the divisor, tick counter and slot table from accepted requests and
// register writes, queues the due tasks each tick should report, and compares
// every strobed result field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module ptd_schedule_checker import ptd_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  ptd_req_t         req,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             result_strobe,
	input  ptd_res_t         result,
	output int               fail_count,
	output int               pending
);

	logic [CFG_W-1:0]    tick_div;
	logic [CFG_W-1:0]    event_cnt;
	logic [TICK_W-1:0]   tick_cnt;
	logic                slot_live [TASK_SLOTS];
	logic                slot_held [TASK_SLOTS];
	logic [PERIOD_W-1:0] slot_per  [TASK_SLOTS];
	logic [OFFSET_W-1:0] slot_off  [TASK_SLOTS];
	ptd_res_t            due_task_q[$];

	function automatic logic slot_is_due(int s, logic [TICK_W-1:0] t);
		if (!slot_live[s] || slot_held[s] || slot_per[s] == '0)
			return 1'b0;
		return (t % TICK_W'(slot_per[s])) == TICK_W'(slot_off[s]);
	endfunction

	// advance the tick and queue every due slot, highest first
	task automatic run_tick();
		int       lowest_due;
		ptd_res_t due;
		tick_cnt   = tick_cnt + 1'b1;
		lowest_due = -1;
		for (int s = 0; s < TASK_SLOTS; s++)
			if (lowest_due < 0 && slot_is_due(s, tick_cnt))
				lowest_due = s;
		for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
			if (slot_is_due(s, tick_cnt)) begin
				due.due_task    = SLOT_FIELD_W'(s);
				due.last_in_run = (s == lowest_due);
				due.tick_value  = tick_cnt;
				due_task_q.push_back(due);
			end
		end
	endtask

	task automatic advance_schedule(ptd_req_t r);
		int divisor;
		if (r.req_type == REQ_TIMER) begin
			divisor = (tick_div == '0) ? 1 : int'(tick_div);
			if (int'(event_cnt) + 1 >= divisor) begin
				event_cnt = '0;
				run_tick();
			end else begin
				event_cnt = event_cnt + 1'b1;
			end
		end else if (r.task_slot < TASK_SLOTS) begin
			case (r.req_type)
				REQ_INSTALL: begin
					slot_live[r.task_slot] = 1'b1;
					slot_held[r.task_slot] = 1'b0;
					slot_per[r.task_slot]  = r.period;
					slot_off[r.task_slot]  = r.phase_offset;
				end
				REQ_DELETE: begin
					slot_live[r.task_slot] = 1'b0;
					slot_held[r.task_slot] = 1'b0;
				end
				REQ_PAUSE:  slot_held[r.task_slot] = 1'b1;
				REQ_RESUME: slot_held[r.task_slot] = 1'b0;
				default: ;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		ptd_res_t exp_res;
		if (!arst_n) begin
			fail_count = 0;
			tick_div  = CFG_W'(1);
			event_cnt = '0;
			tick_cnt  = '0;
			for (int s = 0; s < TASK_SLOTS; s++) begin
				slot_live[s] = 1'b0;
				slot_held[s] = 1'b0;
				slot_per[s]  = '0;
				slot_off[s]  = '0;
			end
			due_task_q.delete();
			pending <= 0;
		end else begin
			if (result_strobe) begin
				if (due_task_q.size() == 0) begin
					$error("unexpected result: due_task %0d last_in_run %0d tick_value %0d",
						result.due_task, result.last_in_run, result.tick_value);
					fail_count++;
				end else begin
					exp_res = due_task_q.pop_front();
					if (result.due_task !== exp_res.due_task) begin
						$error("due_task: expected %0d, got %0d",
							exp_res.due_task, result.due_task);
						fail_count++;
					end
					if (result.last_in_run !== exp_res.last_in_run) begin
						$error("last_in_run: expected %0d, got %0d",
							exp_res.last_in_run, result.last_in_run);
						fail_count++;
					end
					if (result.tick_value !== exp_res.tick_value) begin
						$error("tick_value: expected %0d, got %0d",
							exp_res.tick_value, result.tick_value);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				tick_div = cfg_wdata;
			if (start && !busy)
				advance_schedule(req);
			pending <= due_task_q.size();
		end
	end

endmodule

### tb/periodic_task_dispatcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_tb: testbench top of the periodic task dispatcher
// Drives directed and random table and timer requests under several tick
// divisors and sender gap rates; the checker beside the block predicts the
// due tasks of each tick and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_tb;
	import ptd_pkg::*;

	localparam int          TASK_SLOTS     = TASK_SLOTS_DEF;
	localparam int          DRAIN_CYCLES   = 35 * TASK_SLOTS + 20;
	localparam int          CYCLE_LIMIT    = 1_200_000;
	localparam int          ITEMS_PER_LEG  = 48;
	localparam logic [2:0]  REQ_UNKNOWN_LO = 3'd5;
	localparam logic [2:0]  REQ_UNKNOWN_HI = 3'd7;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	ptd_req_t         req       = '0;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             result_strobe;
	ptd_res_t         result;
	int               fail_count;
	int               pending;
	int               cycle_cnt = 0;

	periodic_task_dispatcher #(.TASK_SLOTS(TASK_SLOTS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_strobe(result_strobe),
		.result       (result)
	);

	ptd_schedule_checker #(.TASK_SLOTS(TASK_SLOTS)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_strobe(result_strobe),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic ptd_req_t make_req(logic [2:0] kind, int slot, int per, int off);
		ptd_req_t r;
		r.req_type     = kind;
		r.task_slot    = SLOT_FIELD_W'(slot);
		r.period       = PERIOD_W'(per);
		r.phase_offset = OFFSET_W'(off);
		return r;
	endfunction

	function automatic ptd_req_t random_request();
		ptd_req_t r;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 48)
			r.req_type = REQ_TIMER;
		else if (pick < 68)
			r.req_type = REQ_INSTALL;
		else if (pick < 76)
			r.req_type = REQ_DELETE;
		else if (pick < 84)
			r.req_type = REQ_PAUSE;
		else if (pick < 92)
			r.req_type = REQ_RESUME;
		else
			r.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
		r.task_slot = ($urandom_range(99) < 85) ? SLOT_FIELD_W'($urandom_range(TASK_SLOTS - 1))
			: SLOT_FIELD_W'($urandom_range(TASK_SLOTS, 15));
		// mostly short periods so tasks actually fall due
		pick = $urandom_range(9);
		if (pick == 0)
			r.period = '0;
		else if (pick <= 2)
			r.period = PERIOD_W'($urandom_range(65535));
		else
			r.period = PERIOD_W'($urandom_range(1, 12));
		if (r.period != '0 && r.period <= 12 && $urandom_range(99) < 85)
			r.phase_offset = OFFSET_W'($urandom_range(r.period - 1));
		else
			r.phase_offset = OFFSET_W'($urandom());
		return r;
	endfunction

	// hold the request until an edge with busy low takes it
	task automatic send_request(ptd_req_t r, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// drop start, wait out every queued result and a full slot walk
	task automatic drain_schedule();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_divisor(int value);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random(int n_items, int idle_pct);
		ptd_req_t r;
		int       counted;
		counted = 0;
		while (counted < n_items) begin
			r = random_request();
			send_request(r, idle_pct);
			// ignored requests do not count toward the leg
			if (r.req_type == REQ_TIMER ||
			    (r.req_type <= REQ_RESUME && r.task_slot < TASK_SLOTS))
				counted++;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_divisor(1);

		// directed table and tick cases
		send_request(make_req(REQ_INSTALL, 7, 1, 0), 0);
		send_request(make_req(REQ_INSTALL, 0, 65535, 255), 0);
		send_request(make_req(REQ_INSTALL, 3, 0, 0), 0);
		send_request(make_req(REQ_INSTALL, 5, 3, 5), 0);
		send_request(make_req(REQ_INSTALL, 15, 2, 1), 0);
		send_request(make_req(REQ_PAUSE, 2, 0, 0), 0);
		send_request(make_req(REQ_INSTALL, 4, 2, 0), 0);
		send_request(make_req(REQ_TIMER, 0, 0, 0), 0);
		send_request(make_req(REQ_TIMER, 15, 65535, 255), 0);
		send_request(make_req(REQ_PAUSE, 7, 0, 0), 0);
		send_request(make_req(REQ_TIMER, 0, 0, 0), 0);
		send_request(make_req(REQ_RESUME, 7, 0, 0), 0);
		send_request(make_req(REQ_RESUME, 2, 0, 0), 0);
		send_request(make_req(REQ_PAUSE, 6, 0, 0), 0);
		send_request(make_req(REQ_INSTALL, 6, 1, 0), 0);
		send_request(make_req(REQ_TIMER, 0, 0, 0), 0);
		send_request(make_req(REQ_DELETE, 4, 0, 0), 0);
		send_request(make_req(REQ_DELETE, 12, 0, 0), 0);
		send_request(make_req(REQ_UNKNOWN_LO, 7, 1, 0), 0);
		send_request(make_req(REQ_UNKNOWN_HI, 6, 1, 0), 0);
		send_request(make_req(REQ_PAUSE, 9, 0, 0), 0);
		send_request(make_req(REQ_TIMER, 0, 0, 0), 0);
		send_request(make_req(REQ_DELETE, 7, 0, 0), 0);
		send_request(make_req(REQ_TIMER, 0, 0, 0), 0);

		// lower the divisor below the events already counted
		drain_schedule();
		write_divisor(5);
		repeat (3) send_request(make_req(REQ_TIMER, 0, 0, 0), 0);
		drain_schedule();
		write_divisor(2);
		send_request(make_req(REQ_TIMER, 0, 0, 0), 0);

		drain_schedule();
		write_divisor(0);
		run_random(ITEMS_PER_LEG, 13);
		drain_schedule();
		write_divisor(3);
		run_random(ITEMS_PER_LEG, 70);
		drain_schedule();
		write_divisor(1);
		run_random(ITEMS_PER_LEG, 0);

		// widest divisor: one tick after 255 events
		drain_schedule();
		write_divisor(255);
		send_request(make_req(REQ_INSTALL, 1, 1, 0), 0);
		repeat (255) send_request(make_req(REQ_TIMER, 0, 0, 0), 0);

		drain_schedule();
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
